// ===== rtl/core/lsbs_pkg.sv =====
// Package of shared types and constants for the least-sent broadcast scheduler.
`default_nettype none
package lsbs_pkg;

  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_PICK   = 3'd2,
    REQ_RECORD = 3'd3,
    REQ_END    = 3'd4
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [63:0] tag;
    logic [15:0] count;
    logic [51:0] time_us;
    logic [31:0] stamp;
  } item_rec_t;

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] item;
  } node_rec_t;

endpackage
`default_nettype wire

// ===== rtl/core/lsbs_if.sv =====
// Request and response channel interfaces of the scheduler.
`default_nettype none
interface lsbs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [63:0] item_tag;
  logic [31:0] node_ident;
  logic        confirmed;
  logic [51:0] now_us;
  modport source(output valid, req_type, item_tag, node_ident, confirmed, now_us,
                 input ready);
  modport sink(input valid, req_type, item_tag, node_ident, confirmed, now_us,
               output ready);
endinterface

interface lsbs_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] out_tag;
  logic [15:0] sent_count;
  modport source(output valid, status, out_tag, sent_count, input ready);
  modport sink(input valid, status, out_tag, sent_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/least_sent_broadcast_scheduler.sv =====
// Top level of the least-sent broadcast scheduler.
//
//  Channel | Dir | Payload                                          | Handshake
//  req     | in  | req_type, item_tag, node_ident, confirmed, now_us | valid/ready
//  rsp     | out | status, out_tag, sent_count                      | valid/ready
//
// Each request walks a memory one entry per cycle through its registered read
// port: add, remove and pick walk the item table, record and end walk the
// node table, and a confirmed end push that finds its node walks both
// tables. One request is served at a time. Reset clears all valid bits and
// the stamp counter at once, so no clearing pass is needed. The response sits
// in an output register, so a new request is taken while the previous
// response still waits to be collected.
`default_nettype none
module least_sent_broadcast_scheduler #(
  parameter int ITEM_ENTRIES = 64,
  parameter int NODE_ENTRIES = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  lsbs_req_if.sink  req,
  lsbs_rsp_if.source rsp
);
  localparam int IW = $clog2(ITEM_ENTRIES);
  localparam int NW = $clog2(NODE_ENTRIES);
  localparam int CW = ((IW > NW) ? IW : NW) + 1;
  localparam int IRW = $bits(lsbs_pkg::item_rec_t);
  localparam int NRW = $bits(lsbs_pkg::node_rec_t);

  typedef enum logic [2:0] {S_IDLE, S_ISCAN, S_NSCAN, S_OUT} state_t;

  state_t state;

  // Captured request.
  lsbs_pkg::req_kind_t kind;
  logic [63:0] match_tag;
  logic [31:0] key;
  logic        conf;
  logic [51:0] now;

  // Scan sequencing: scan_idx is the address being read, pidx the entry whose
  // data is on the read port in this cycle.
  logic [CW-1:0] scan_idx;
  logic [CW-1:0] pidx;
  logic          pend;

  logic [ITEM_ENTRIES-1:0] entry_valid;
  logic [NODE_ENTRIES-1:0] node_valid;
  logic [31:0]             stamp_counter;

  // Scan results.
  logic          found;
  logic [IW-1:0] found_idx;
  logic [15:0]   hit_count;
  logic          free;
  logic [IW-1:0] free_idx;
  logic          best_valid;
  logic [99:0]   best_key;
  logic [63:0]   best_tag;
  logic          nfound;
  logic [NW-1:0] nfound_idx;
  logic [63:0]   nhit_item;
  logic          nfree;
  logic [NW-1:0] nfree_idx;

  // Memory write requests, registered.
  logic          item_we;
  logic [IW-1:0] item_waddr;
  lsbs_pkg::item_rec_t item_wrec;
  logic          node_we;
  logic [NW-1:0] node_waddr;
  lsbs_pkg::node_rec_t node_wrec;

  // Response staging and output register.
  lsbs_pkg::status_t res_status;
  logic [63:0]       res_tag;
  logic [15:0]       res_count;
  logic              rsp_valid;
  lsbs_pkg::status_t rsp_status;
  logic [63:0]       rsp_tag;
  logic [15:0]       rsp_count;

  logic [IRW-1:0] item_rdata;
  logic [NRW-1:0] node_rdata;
  lsbs_pkg::item_rec_t irec;
  lsbs_pkg::node_rec_t nrec;
  logic [99:0] ikey;
  logic        iv;
  logic        nv;
  logic        iscan_end;
  logic        nscan_end;

  lsbs_ram #(.WIDTH(IRW), .DEPTH(ITEM_ENTRIES)) u_item_ram (
    .clk   (clk),
    .we    (item_we),
    .waddr (item_waddr),
    .wdata (item_wrec),
    .raddr (scan_idx[IW-1:0]),
    .rdata (item_rdata)
  );

  lsbs_ram #(.WIDTH(NRW), .DEPTH(NODE_ENTRIES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wrec),
    .raddr (scan_idx[NW-1:0]),
    .rdata (node_rdata)
  );

  always_comb begin
    irec = lsbs_pkg::item_rec_t'(item_rdata);
    nrec = lsbs_pkg::node_rec_t'(node_rdata);
    ikey = {irec.count, irec.time_us, irec.stamp};
    iv   = entry_valid[pidx[IW-1:0]];
    nv   = node_valid[pidx[NW-1:0]];
    // The walk is over once every address has been issued and the last read
    // data has been looked at.
    iscan_end = (scan_idx == CW'(ITEM_ENTRIES)) && !pend;
    nscan_end = (scan_idx == CW'(NODE_ENTRIES)) && !pend;
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.out_tag    = rsp_tag;
  assign rsp.sent_count = rsp_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_valid   <= '0;
      node_valid    <= '0;
      stamp_counter <= '0;
      rsp_valid     <= 1'b0;
      item_we       <= 1'b0;
      node_we       <= 1'b0;
      pend          <= 1'b0;
    end else begin
      // A write strobe is raised at the end of a walk and lasts one cycle.
      if (state != S_ISCAN) begin
        item_we <= 1'b0;
      end
      if (state != S_NSCAN) begin
        node_we <= 1'b0;
      end
      // In S_OUT a collected response is replaced by the next one below.
      if (rsp.valid && rsp.ready && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind       <= lsbs_pkg::req_kind_t'(req.req_type);
            match_tag  <= req.item_tag;
            key        <= req.node_ident;
            conf       <= req.confirmed;
            now        <= req.now_us;
            scan_idx   <= '0;
            pend       <= 1'b0;
            found      <= 1'b0;
            free       <= 1'b0;
            best_valid <= 1'b0;
            nfound     <= 1'b0;
            nfree      <= 1'b0;
            res_status <= lsbs_pkg::ST_DONE;
            res_tag    <= '0;
            res_count  <= '0;
            if (req.req_type == lsbs_pkg::REQ_ADD || req.req_type == lsbs_pkg::REQ_REMOVE ||
                req.req_type == lsbs_pkg::REQ_PICK) begin
              state <= S_ISCAN;
            end else if (req.req_type == lsbs_pkg::REQ_RECORD ||
                         req.req_type == lsbs_pkg::REQ_END) begin
              state <= S_NSCAN;
            end else begin
              state <= S_OUT;
            end
          end
        end

        S_ISCAN: begin
          if (scan_idx != CW'(ITEM_ENTRIES)) begin
            scan_idx <= scan_idx + 1'b1;
            pidx     <= scan_idx;
            pend     <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (iv && irec.tag == match_tag && !found) begin
              found     <= 1'b1;
              found_idx <= pidx[IW-1:0];
              hit_count <= irec.count;
            end
            if (!iv && !free) begin
              free     <= 1'b1;
              free_idx <= pidx[IW-1:0];
            end
            // Strictly less keeps the lowest index among equal keys.
            if (iv && (!best_valid || ikey < best_key)) begin
              best_valid <= 1'b1;
              best_key   <= ikey;
              best_tag   <= irec.tag;
            end
          end
          if (iscan_end) begin
            state <= S_OUT;
            unique case (kind)
              lsbs_pkg::REQ_ADD: begin
                if (!found) begin
                  if (!free) begin
                    res_status <= lsbs_pkg::ST_FULL;
                  end else begin
                    entry_valid[free_idx] <= 1'b1;
                    item_we               <= 1'b1;
                    item_waddr            <= free_idx;
                    item_wrec             <= '{tag: match_tag, count: 16'd0,
                                               time_us: 52'd0, stamp: stamp_counter};
                    stamp_counter         <= stamp_counter + 32'd1;
                  end
                end
              end
              lsbs_pkg::REQ_REMOVE: begin
                if (found) begin
                  entry_valid[found_idx] <= 1'b0;
                  res_count              <= hit_count;
                end else begin
                  res_status <= lsbs_pkg::ST_ABSENT;
                end
              end
              lsbs_pkg::REQ_PICK: begin
                if (best_valid) begin
                  res_tag <= best_tag;
                end else begin
                  res_status <= lsbs_pkg::ST_ABSENT;
                end
              end
              default: begin
                // Confirmed end push: refresh the pushed item if still present.
                if (found) begin
                  item_we       <= 1'b1;
                  item_waddr    <= found_idx;
                  item_wrec     <= '{tag: match_tag,
                                     count: (hit_count == lsbs_pkg::COUNT_MAX) ?
                                            hit_count : hit_count + 16'd1,
                                     time_us: now, stamp: stamp_counter};
                  stamp_counter <= stamp_counter + 32'd1;
                end
              end
            endcase
          end
        end

        S_NSCAN: begin
          if (scan_idx != CW'(NODE_ENTRIES)) begin
            scan_idx <= scan_idx + 1'b1;
            pidx     <= scan_idx;
            pend     <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (nv && nrec.key == key && !nfound) begin
              nfound     <= 1'b1;
              nfound_idx <= pidx[NW-1:0];
              nhit_item  <= nrec.item;
            end
            if (!nv && !nfree) begin
              nfree     <= 1'b1;
              nfree_idx <= pidx[NW-1:0];
            end
          end
          if (nscan_end) begin
            if (kind == lsbs_pkg::REQ_RECORD) begin
              state <= S_OUT;
              if (!nfound) begin
                if (!nfree) begin
                  res_status <= lsbs_pkg::ST_FULL;
                end else begin
                  node_valid[nfree_idx] <= 1'b1;
                  node_we               <= 1'b1;
                  node_waddr            <= nfree_idx;
                  node_wrec             <= '{key: key, item: match_tag};
                end
              end
            end else if (!nfound) begin
              state      <= S_OUT;
              res_status <= lsbs_pkg::ST_ABSENT;
            end else begin
              node_valid[nfound_idx] <= 1'b0;
              if (conf) begin
                // Walk the item table for the tag the node was pushed.
                match_tag <= nhit_item;
                scan_idx  <= '0;
                found     <= 1'b0;
                state     <= S_ISCAN;
              end else begin
                state <= S_OUT;
              end
            end
          end
        end

        S_OUT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_tag    <= res_tag;
            rsp_count  <= res_count;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Memory writes are issued only as a request completes.
  a_item_we_at_out: assert property (@(posedge clk) disable iff (rst)
    item_we |-> state == S_OUT)
    else $error("item table written outside completion");

  // The stamp counter moves only together with an item table write.
  a_stamp_with_write: assert property (@(posedge clk) disable iff (rst)
    !$stable(stamp_counter) |-> item_we)
    else $error("stamp counter moved without an entry write");

  // One request at a time: acceptance closes the request channel.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in progress");

endmodule
`default_nettype wire

// ===== rtl/core/lsbs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module lsbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== verif/least_sent_broadcast_scheduler_tb.sv =====
// Self-checking testbench, least-sent broadcast scheduler: rows, overflow fills, random requests.
`default_nettype none
module least_sent_broadcast_scheduler_tb;

  localparam int ITEMS = 64;
  localparam int NODES = 32;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  lsbs_req_if req ();
  lsbs_rsp_if rsp ();

  least_sent_broadcast_scheduler #(.ITEM_ENTRIES(ITEMS), .NODE_ENTRIES(NODES)) dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  // Shadow copy of the scheduler's two tables.
  logic        sh_valid [ITEMS];
  logic [63:0] sh_tag   [ITEMS];
  logic [15:0] sh_count [ITEMS];
  logic [51:0] sh_time  [ITEMS];
  logic [31:0] sh_stamp [ITEMS];
  logic [31:0] sh_next_stamp;
  logic        nd_valid [NODES];
  logic [31:0] nd_key   [NODES];
  logic [63:0] nd_item  [NODES];

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] tag;
    logic [15:0] count;
  } answer_t;

  // A row of the directed table; check_now means the answer column is to be used as typed.
  typedef struct packed {
    lsbs_pkg::req_kind_t kind;
    logic [63:0] tag;
    logic [31:0] node;
    logic        conf;
    logic [51:0] now;
    logic        check_now;
    answer_t     answer;
  } row_t;

  answer_t pending_answers[$];
  int      failures = 0;
  int      requests_sent = 0;
  int      answers_seen = 0;
  int      kind_seen [5];
  int      idle_cycles = 0;
  bit      calm = 1'b0;

  // Tag pools keep collisions common so that removes, repeats and pushes find their items.
  logic [63:0] tag_pool [8];
  logic [31:0] node_pool [6];

  function automatic int find_tag(logic [63:0] t);
    for (int i = 0; i < ITEMS; i++)
      if (sh_valid[i] && sh_tag[i] == t) return i;
    return -1;
  endfunction

  function automatic int find_node_slot(logic [31:0] k);
    for (int i = 0; i < NODES; i++)
      if (nd_valid[i] && nd_key[i] == k) return i;
    return -1;
  endfunction

  function automatic bit ranks_lower(int a, int b);
    if (sh_count[a] != sh_count[b]) return sh_count[a] < sh_count[b];
    if (sh_time[a] != sh_time[b]) return sh_time[a] < sh_time[b];
    return sh_stamp[a] < sh_stamp[b];
  endfunction

  // Serves one request on the shadow tables and returns the answer the block owes.
  function automatic answer_t schedule_step(lsbs_pkg::req_kind_t kind, logic [63:0] t,
                                            logic [31:0] n, logic c, logic [51:0] now);
    answer_t a;
    int k;
    int j;
    a = '0;
    case (kind)
      lsbs_pkg::REQ_ADD: begin
        if (find_tag(t) < 0) begin
          k = -1;
          for (int i = 0; i < ITEMS; i++)
            if (!sh_valid[i] && k < 0) k = i;
          if (k < 0) begin
            a.status = lsbs_pkg::ST_FULL;
          end else begin
            sh_valid[k] = 1'b1;
            sh_tag[k] = t;
            sh_count[k] = '0;
            sh_time[k] = '0;
            sh_stamp[k] = sh_next_stamp;
            sh_next_stamp++;
          end
        end
      end
      lsbs_pkg::REQ_REMOVE: begin
        k = find_tag(t);
        if (k < 0) begin
          a.status = lsbs_pkg::ST_ABSENT;
        end else begin
          a.count = sh_count[k];
          sh_valid[k] = 1'b0;
        end
      end
      lsbs_pkg::REQ_PICK: begin
        k = -1;
        for (int i = 0; i < ITEMS; i++)
          if (sh_valid[i] && (k < 0 || ranks_lower(i, k))) k = i;
        if (k < 0) a.status = lsbs_pkg::ST_ABSENT;
        else a.tag = sh_tag[k];
      end
      lsbs_pkg::REQ_RECORD: begin
        if (find_node_slot(n) < 0) begin
          k = -1;
          for (int i = 0; i < NODES; i++)
            if (!nd_valid[i] && k < 0) k = i;
          if (k < 0) begin
            a.status = lsbs_pkg::ST_FULL;
          end else begin
            nd_valid[k] = 1'b1;
            nd_key[k] = n;
            nd_item[k] = t;
          end
        end
      end
      lsbs_pkg::REQ_END: begin
        k = find_node_slot(n);
        if (k < 0) begin
          a.status = lsbs_pkg::ST_ABSENT;
        end else begin
          nd_valid[k] = 1'b0;
          j = find_tag(nd_item[k]);
          if (c && j >= 0) begin
            if (sh_count[j] != lsbs_pkg::COUNT_MAX) sh_count[j]++;
            sh_time[j] = now;
            sh_stamp[j] = sh_next_stamp;
            sh_next_stamp++;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Drives one request at the falling edge and holds it until accepted.
  task automatic send_request(lsbs_pkg::req_kind_t kind, logic [63:0] t, logic [31:0] n,
                              logic c, logic [51:0] now);
    if (!calm && $urandom_range(99) < 35) begin
      req.valid <= 1'b0;
      @(negedge clk);
      while (!calm && $urandom_range(99) < 35) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.item_tag <= t;
    req.node_ident <= n;
    req.confirmed <= c;
    req.now_us <= now;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_answers.push_back(schedule_step(kind, t, n, c, now));
    requests_sent++;
    kind_seen[kind]++;
    @(negedge clk);
  endtask

  // Response side: random backpressure, then compare against the oldest expectation.
  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= calm || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $error("response with no request outstanding");
        failures++;
      end else begin
        want = pending_answers.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          failures++;
        end
        if (rsp.out_tag !== want.tag) begin
          $error("out_tag: expected %h, got %h", want.tag, rsp.out_tag);
          failures++;
        end
        if (rsp.sent_count !== want.count) begin
          $error("sent_count: expected %0d, got %0d", want.count, rsp.sent_count);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] wide_random();
    return {$urandom(), $urandom()};
  endfunction

  row_t rows [$];
  row_t r;
  answer_t got;
  int pick;

  initial begin
    req.valid = 1'b0;
    req.req_type = lsbs_pkg::REQ_ADD;
    req.item_tag = '0;
    req.node_ident = '0;
    req.confirmed = 1'b0;
    req.now_us = '0;
    for (int i = 0; i < ITEMS; i++) sh_valid[i] = 1'b0;
    for (int i = 0; i < NODES; i++) nd_valid[i] = 1'b0;
    sh_next_stamp = '0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    foreach (tag_pool[i]) tag_pool[i] = wide_random();
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    foreach (node_pool[i]) node_pool[i] = $urandom();
    node_pool[0] = '0;
    node_pool[1] = '1;

    // Directed table: empty-table answers, extremes, duplicates and the push cycle.
    rows.push_back('{lsbs_pkg::REQ_PICK, 64'h0, 32'h0, 1'b0, 52'h0, 1'b1,
                     '{lsbs_pkg::ST_ABSENT, 64'h0, 16'h0}});
    rows.push_back('{lsbs_pkg::REQ_REMOVE, '1, 32'h0, 1'b0, 52'h0, 1'b1,
                     '{lsbs_pkg::ST_ABSENT, 64'h0, 16'h0}});
    rows.push_back('{lsbs_pkg::REQ_END, 64'h0, '1, 1'b1, '1, 1'b1,
                     '{lsbs_pkg::ST_ABSENT, 64'h0, 16'h0}});
    rows.push_back('{lsbs_pkg::REQ_ADD, '1, 32'h0, 1'b0, 52'h0, 1'b1,
                     '{lsbs_pkg::ST_DONE, 64'h0, 16'h0}});
    rows.push_back('{lsbs_pkg::REQ_ADD, 64'h0, 32'h0, 1'b0, 52'h0, 1'b1,
                     '{lsbs_pkg::ST_DONE, 64'h0, 16'h0}});
    rows.push_back('{lsbs_pkg::REQ_ADD, '1, 32'h0, 1'b0, 52'h0, 1'b1,
                     '{lsbs_pkg::ST_DONE, 64'h0, 16'h0}});
    rows.push_back('{lsbs_pkg::REQ_PICK, 64'h0, 32'h0, 1'b0, 52'h0, 1'b1,
                     '{lsbs_pkg::ST_DONE, '1, 16'h0}});
    rows.push_back('{lsbs_pkg::REQ_RECORD, '1, '1, 1'b0, 52'h0, 1'b0, '0});
    rows.push_back('{lsbs_pkg::REQ_RECORD, 64'h0, '1, 1'b0, 52'h0, 1'b0, '0});
    rows.push_back('{lsbs_pkg::REQ_END, 64'h0, '1, 1'b1, '1, 1'b0, '0});
    rows.push_back('{lsbs_pkg::REQ_PICK, 64'h0, 32'h0, 1'b0, 52'h0, 1'b1,
                     '{lsbs_pkg::ST_DONE, 64'h0, 16'h0}});
    rows.push_back('{lsbs_pkg::REQ_RECORD, 64'h0, 32'h0, 1'b0, 52'h0, 1'b0, '0});
    rows.push_back('{lsbs_pkg::REQ_END, 64'h0, 32'h0, 1'b0, 52'h5, 1'b0, '0});
    rows.push_back('{lsbs_pkg::REQ_REMOVE, '1, 32'h0, 1'b0, 52'h0, 1'b1,
                     '{lsbs_pkg::ST_DONE, 64'h0, 16'h1}});
    rows.push_back('{lsbs_pkg::REQ_REMOVE, 64'h0, 32'h0, 1'b0, 52'h0, 1'b1,
                     '{lsbs_pkg::ST_DONE, 64'h0, 16'h0}});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      r = rows[i];
      send_request(r.kind, r.tag, r.node, r.conf, r.now);
      if (r.check_now) begin
        got = pending_answers[$];
        if (got !== r.answer) begin
          $error("row %0d answer: expected %h, got %h", i, r.answer, got);
          failures++;
        end
      end
    end

    // Overflow the item table, then the node table; then end every node and remove every item.
    for (int i = 0; i <= ITEMS; i++)
      send_request(lsbs_pkg::REQ_ADD, wide_random(), '0, 1'b0, '0);
    for (int i = 0; i <= NODES; i++)
      send_request(lsbs_pkg::REQ_RECORD, sh_tag[i % ITEMS], $urandom(), 1'b0, '0);
    for (int i = 0; i < NODES; i++)
      if (nd_valid[i])
        send_request(lsbs_pkg::REQ_END, '0, nd_key[i], 1'b1, 52'(wide_random()));
    for (int i = 0; i < ITEMS; i++)
      if (sh_valid[i]) send_request(lsbs_pkg::REQ_REMOVE, sh_tag[i], '0, 1'b0, '0);

    // Random part: mostly add / push / end cycles on a small tag pool, some noise.
    for (int n = 0; n < 340; n++) begin
      calm = (n >= 200 && n < 260);
      pick = $urandom_range(99);
      if (pick < 22)
        send_request(lsbs_pkg::REQ_ADD, tag_pool[$urandom_range(7)], $urandom(),
                     1'($urandom()), '0);
      else if (pick < 34)
        send_request(lsbs_pkg::REQ_REMOVE, $urandom_range(9) == 0 ? wide_random()
                     : tag_pool[$urandom_range(7)], '0, 1'b0, '0);
      else if (pick < 52)
        send_request(lsbs_pkg::REQ_PICK, wide_random(), $urandom(), 1'($urandom()),
                     52'(wide_random()));
      else if (pick < 74)
        send_request(lsbs_pkg::REQ_RECORD, tag_pool[$urandom_range(7)],
                     node_pool[$urandom_range(5)], 1'b0, '0);
      else
        send_request(lsbs_pkg::REQ_END, '0, $urandom_range(9) == 0 ? $urandom()
                     : node_pool[$urandom_range(5)], $urandom_range(3) != 0,
                     $urandom_range(3) == 0 ? 52'(wide_random()) : 52'($urandom_range(7)));
    end
    calm = 1'b0;
    req.valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d requests (add %0d, remove %0d, pick %0d, record %0d, end %0d),",
             requests_sent, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4]);
    $display("including both tables filled past capacity; %0d responses checked.",
             answers_seen);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
